/* hdl/assert_macros.svh */
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CHK_IMP(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define CHK_NEXT(lbl, clk_sig, rst_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define CHK_NEXT_ALWAYS(lbl, clk_sig, ante, cons, msg) \
  lbl: assert property (@(posedge clk_sig) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cdrc_pkg.sv */
`default_nettype none

package cdrc_pkg;

  // Printable window on the low seven bits of a byte.
  localparam logic [6:0] PRINT_LO = 7'h20;
  localparam logic [6:0] PRINT_HI = 7'h7E;

  localparam int RUN_BITS  = 5;
  localparam int EQ_BITS   = 3;
  localparam int LONG_BITS = 2;

  localparam logic [RUN_BITS-1:0]  RUN_MAX    = '1;
  localparam logic [RUN_BITS-1:0]  RUN_TERM   = 5'd3;
  localparam logic [RUN_BITS-1:0]  RUN_LONG   = 5'd5;
  localparam logic [RUN_BITS-1:0]  RUN_SHARE  = 5'd10;
  localparam logic [RUN_BITS-1:0]  RUN_STRONG = 5'd20;
  localparam logic [EQ_BITS-1:0]   EQ_ONE     = 3'd1;
  localparam logic [EQ_BITS-1:0]   EQ_MAX     = '1;
  localparam logic [EQ_BITS-1:0]   EQ_REPEAT  = 3'd4;
  localparam logic [LONG_BITS-1:0] LONG_MAX   = '1;
  localparam logic [EQ_BITS-1:0]   LONG_NEEDED = 3'd2;

  localparam logic [15:0] ADDR_HI_MIN   = 16'h0800;
  localparam logic [15:0] ADDR_LO_LIMIT = 16'h0100;

  localparam int MIN_BYTES      = 4;
  localparam int PAIR_MIN_BYTES = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic        looks_like_data;
    logic [15:0] region_bytes;
  } verdict_t;

endpackage

`default_nettype wire

/* hdl/code_or_data_region_classifier.sv */
// Classifies a region of bytes as data or code.
// Input channel (in_valid/in_ready): one byte of the region per transaction,
// with last_byte set on the final byte. Output channel (out_valid/out_ready):
// one verdict per region, looks_like_data plus the saturated count's low 16 bits.
// Each byte lands in an input register; from there it updates the running
// counters and, on the final byte, the verdict is registered in the result
// register, which raises out_valid. Throughput is one byte per cycle while
// no final byte is stalled behind a waiting verdict; the counter update lies
// between the input register and the result register.
// While a verdict waits on out_ready, bytes keep being taken; only a second
// final byte stalls, and then in_ready drops until the verdict is taken.
// Reset empties both registers and clears all counters to a fresh region.

`default_nettype none

module code_or_data_region_classifier #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             looks_like_data,
  output logic [15:0]      region_bytes
);

  cdrc_pkg::item_t    item;
  logic               item_valid;
  logic               advance;
  cdrc_pkg::verdict_t verdict;
  cdrc_pkg::verdict_t result;

  // A held byte moves on unless it is a final byte and the result slot is stalled.
  assign advance  = item_valid && (!item.last_byte || !out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      item.data_byte <= data_byte;
      item.last_byte <= last_byte;
    end
  end

  cdrc_tally #(
    .COUNT_BITS(COUNT_BITS)
  ) u_tally (
    .clk     (clk),
    .rst     (rst),
    .take    (advance),
    .item    (item),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance && item.last_byte) begin
      result <= verdict;
    end
  end

  assign looks_like_data = result.looks_like_data;
  assign region_bytes    = result.region_bytes;

endmodule

`default_nettype wire

/* hdl/cdrc_tally.sv */
`default_nettype none

module cdrc_tally #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire cdrc_pkg::item_t    item,
  output cdrc_pkg::verdict_t      verdict
);

  localparam int EXT_BITS  = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int WIDE_BITS = COUNT_BITS + 3;

  logic [COUNT_BITS-1:0]          byte_count, byte_count_next;
  logic [COUNT_BITS-1:0]          print_count, print_count_next;
  logic [COUNT_BITS-1:0]          address_pair_count, address_pair_count_next;
  logic [cdrc_pkg::RUN_BITS-1:0]  printable_run, printable_run_next;
  logic [cdrc_pkg::RUN_BITS-1:0]  longest_printable_run, longest_printable_run_next;
  logic [cdrc_pkg::LONG_BITS-1:0] long_run_count, long_run_count_next;
  logic [7:0]                     previous_byte, previous_byte_next;
  logic [cdrc_pkg::EQ_BITS-1:0]   equal_run, equal_run_next;
  logic                           repeat_seen, repeat_seen_next;
  logic                           terminated_string_seen, terminated_string_seen_next;
  logic [7:0]                     pair_low_byte, pair_low_byte_next;
  logic                           pair_phase, pair_phase_next;

  logic [6:0]                   low7;
  logic                         printable;
  logic                         first;
  logic [cdrc_pkg::EQ_BITS-1:0] equal_inc;
  logic [15:0]                  pair_value;
  logic                         addr_like;
  logic [cdrc_pkg::EQ_BITS-1:0] runs;
  logic [WIDE_BITS-1:0]         p_times5, n_times4, n_times3;
  logic [EXT_BITS-1:0]          n_ext;
  logic                         data;

  always_comb begin
    low7      = item.data_byte[6:0];
    printable = (low7 >= cdrc_pkg::PRINT_LO) && (low7 <= cdrc_pkg::PRINT_HI);
    first     = (byte_count == '0);

    // A zero byte closes a string only if at least three printable bytes led up to it.
    terminated_string_seen_next = terminated_string_seen |
        ((item.data_byte == 8'h00) && !item.last_byte &&
         (printable_run >= cdrc_pkg::RUN_TERM));

    if (printable) begin
      printable_run_next = (printable_run != cdrc_pkg::RUN_MAX) ?
                           printable_run + 1'b1 : printable_run;
      longest_printable_run_next = (printable_run_next > longest_printable_run) ?
                                   printable_run_next : longest_printable_run;
      long_run_count_next = long_run_count;
    end else begin
      printable_run_next         = '0;
      longest_printable_run_next = longest_printable_run;
      long_run_count_next = ((printable_run >= cdrc_pkg::RUN_LONG) &&
                             (long_run_count != cdrc_pkg::LONG_MAX)) ?
                            long_run_count + 1'b1 : long_run_count;
    end

    equal_inc = (equal_run != cdrc_pkg::EQ_MAX) ? equal_run + 1'b1 : equal_run;
    previous_byte_next = previous_byte;
    equal_run_next     = equal_run;
    repeat_seen_next   = repeat_seen;
    if (first) begin
      previous_byte_next = item.data_byte;
      equal_run_next     = cdrc_pkg::EQ_ONE;
    end else if (item.data_byte == previous_byte) begin
      equal_run_next = equal_inc;
      if (equal_inc >= cdrc_pkg::EQ_REPEAT) begin
        repeat_seen_next = 1'b1;
      end
    end else begin
      equal_run_next     = cdrc_pkg::EQ_ONE;
      previous_byte_next = item.data_byte;
    end

    // Little-endian pairs; a pair whose high byte ends the region is not counted.
    pair_value = {item.data_byte, pair_low_byte};
    addr_like  = (pair_value >= cdrc_pkg::ADDR_HI_MIN) ||
                 (pair_value < cdrc_pkg::ADDR_LO_LIMIT);
    pair_low_byte_next = pair_phase ? pair_low_byte : item.data_byte;
    pair_phase_next    = !pair_phase;
    address_pair_count_next = (pair_phase && !item.last_byte && addr_like &&
                               (address_pair_count != '1)) ?
                              address_pair_count + 1'b1 : address_pair_count;

    byte_count_next = (byte_count != '1) ? byte_count + 1'b1 : byte_count;
    print_count_next = (printable && (print_count != '1)) ?
                       print_count + 1'b1 : print_count;

    runs = cdrc_pkg::EQ_BITS'(long_run_count_next) +
           cdrc_pkg::EQ_BITS'(printable_run_next >= cdrc_pkg::RUN_LONG);

    // Shares are compared as 5*p against 4*n and 3*n.
    p_times5 = (WIDE_BITS'(print_count_next) << 2) + WIDE_BITS'(print_count_next);
    n_times4 = WIDE_BITS'(byte_count_next) << 2;
    n_times3 = (WIDE_BITS'(byte_count_next) << 1) + WIDE_BITS'(byte_count_next);

    data = (byte_count_next >= COUNT_BITS'(cdrc_pkg::MIN_BYTES)) &&
           ((longest_printable_run_next >= cdrc_pkg::RUN_STRONG) ||
            ((p_times5 > n_times4) &&
             (longest_printable_run_next >= cdrc_pkg::RUN_SHARE)) ||
            ((runs >= cdrc_pkg::LONG_NEEDED) && (p_times5 > n_times3)) ||
            repeat_seen_next ||
            terminated_string_seen_next ||
            ((byte_count_next >= COUNT_BITS'(cdrc_pkg::PAIR_MIN_BYTES)) &&
             (address_pair_count_next >= (byte_count_next >> 2))));

    n_ext                   = EXT_BITS'(byte_count_next);
    verdict.looks_like_data = data;
    verdict.region_bytes    = n_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst || (take && item.last_byte)) begin
      byte_count             <= '0;
      print_count            <= '0;
      address_pair_count     <= '0;
      printable_run          <= '0;
      longest_printable_run  <= '0;
      long_run_count         <= '0;
      previous_byte          <= '0;
      equal_run              <= cdrc_pkg::EQ_ONE;
      repeat_seen            <= 1'b0;
      terminated_string_seen <= 1'b0;
      pair_low_byte          <= '0;
      pair_phase             <= 1'b0;
    end else if (take) begin
      byte_count             <= byte_count_next;
      print_count            <= print_count_next;
      address_pair_count     <= address_pair_count_next;
      printable_run          <= printable_run_next;
      longest_printable_run  <= longest_printable_run_next;
      long_run_count         <= long_run_count_next;
      previous_byte          <= previous_byte_next;
      equal_run              <= equal_run_next;
      repeat_seen            <= repeat_seen_next;
      terminated_string_seen <= terminated_string_seen_next;
      pair_low_byte          <= pair_low_byte_next;
      pair_phase             <= pair_phase_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/cdrc_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module cdrc_checker #(
  parameter int COUNT_BITS = 16
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        looks_like_data,
  input wire logic [15:0] region_bytes
);

  `CHK_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(looks_like_data) && $stable(region_bytes), "stalled verdict changed")
  `CHK_IMP(a_no_empty_region, clk, rst, out_valid && (COUNT_BITS <= 16), region_bytes != 16'h0000, "verdict for an empty region")
  `CHK_IMP(a_short_is_code, clk, rst, out_valid && looks_like_data && (COUNT_BITS <= 16), region_bytes >= 16'd4, "short region marked as data")
  `CHK_IMP(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")
  `CHK_NEXT_ALWAYS(a_reset_empties, clk, rst, !out_valid && in_ready, "reset left a transaction in flight")

endmodule

bind code_or_data_region_classifier cdrc_checker #(
  .COUNT_BITS(COUNT_BITS)
) u_cdrc_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .looks_like_data (looks_like_data),
  .region_bytes    (region_bytes)
);

`default_nettype wire

/* tb/sv/code_or_data_region_classifier_tb.sv */
`default_nettype none

module code_or_data_region_classifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;

  typedef enum int {
    RG_NOISE,
    RG_TEXT,
    RG_CSTRING,
    RG_REPEAT,
    RG_ADDR,
    RG_RUNS,
    RG_CODE
  } region_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        looks_like_data;
  logic [15:0] region_bytes;

  cdrc_pkg::item_t    byte_stream[$];
  cdrc_pkg::verdict_t verdicts_due[$];
  cdrc_pkg::verdict_t oldest_verdict;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int errors = 0;
  int regions_queued = 0;
  int bytes_queued = 0;
  int verdicts_checked = 0;
  int data_verdicts = 0;
  int cycle_cnt = 0;

  // Running view of the region, mirrored from the accepted bytes.
  logic [15:0] seen_bytes;
  logic [15:0] seen_printable;
  logic [15:0] addr_pairs;
  logic [4:0]  text_run;
  logic [4:0]  longest_run;
  logic [1:0]  long_runs;
  logic [7:0]  run_byte;
  logic [2:0]  same_run;
  logic        repeat_found;
  logic        cstring_found;
  logic [7:0]  pair_low;
  logic        pair_open;

  code_or_data_region_classifier #(
    .COUNT_BITS(16)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .looks_like_data(looks_like_data),
    .region_bytes   (region_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d verdicts still due", cycle_cnt,
             verdicts_due.size());
    $display("Verification failed");
    $finish;
  end

  function automatic void clear_region();
    seen_bytes     = '0;
    seen_printable = '0;
    addr_pairs     = '0;
    text_run       = '0;
    longest_run    = '0;
    long_runs      = '0;
    run_byte       = '0;
    same_run       = 3'd1;
    repeat_found   = 1'b0;
    cstring_found  = 1'b0;
    pair_low       = '0;
    pair_open      = 1'b0;
  endfunction

  function automatic void classify_byte(input logic [7:0] b, input logic fin);
    logic               printable;
    logic               starting;
    logic [15:0]        pair_val;
    cdrc_pkg::verdict_t v;
    int                 n;
    int                 p;
    int                 runs;
    printable = (b[6:0] >= cdrc_pkg::PRINT_LO) && (b[6:0] <= cdrc_pkg::PRINT_HI);
    starting  = (seen_bytes == 0);

    // A NUL counts as a string end only when more bytes follow it.
    if (b == 8'h00 && !fin && text_run >= 3)
      cstring_found = 1'b1;

    if (printable) begin
      if (text_run != 5'd31)
        text_run++;
      if (text_run > longest_run)
        longest_run = text_run;
    end else begin
      if (text_run >= 5 && long_runs != 2'd3)
        long_runs++;
      text_run = '0;
    end

    if (starting) begin
      run_byte = b;
      same_run = 3'd1;
    end else if (b == run_byte) begin
      if (same_run != 3'd7)
        same_run++;
      if (same_run >= 4)
        repeat_found = 1'b1;
    end else begin
      run_byte = b;
      same_run = 3'd1;
    end

    if (!pair_open) begin
      pair_low  = b;
      pair_open = 1'b1;
    end else begin
      pair_val  = {b, pair_low};
      pair_open = 1'b0;
      if (!fin && (pair_val >= 16'h0800 || pair_val < 16'h0100) && addr_pairs != 16'hFFFF)
        addr_pairs++;
    end

    if (seen_bytes != 16'hFFFF)
      seen_bytes++;
    if (printable && seen_printable != 16'hFFFF)
      seen_printable++;

    if (fin) begin
      n    = seen_bytes;
      p    = seen_printable;
      runs = long_runs + ((text_run >= 5) ? 1 : 0);
      v.looks_like_data = 1'b0;
      if (n >= 4) begin
        if (longest_run >= 20)
          v.looks_like_data = 1'b1;
        else if (p * 5 > n * 4 && longest_run >= 10)
          v.looks_like_data = 1'b1;
        else if (runs >= 2 && p * 5 > n * 3)
          v.looks_like_data = 1'b1;
        else if (repeat_found || cstring_found)
          v.looks_like_data = 1'b1;
        else if (n >= 8 && addr_pairs >= n / 4)
          v.looks_like_data = 1'b1;
      end
      v.region_bytes = seen_bytes;
      verdicts_due.push_back(v);
      clear_region();
    end
  endfunction

  // Byte driver; a transaction's payload is folded into the prediction on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        classify_byte(data_byte, last_byte);
      if (!in_valid || in_ready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          data_byte <= byte_stream[0].data_byte;
          last_byte <= byte_stream[0].last_byte;
          void'(byte_stream.pop_front());
        end else begin
          in_valid  <= 1'b0;
          data_byte <= 8'($urandom);
          last_byte <= 1'($urandom);
        end
      end
    end
  end

  // Verdict monitor.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: expected no verdict, got data=%0b bytes=%0d", $time,
                   looks_like_data, region_bytes);
          errors++;
        end else begin
          oldest_verdict = verdicts_due.pop_front();
          if (looks_like_data !== oldest_verdict.looks_like_data) begin
            $display("%0t: looks_like_data expected %0b got %0b (bytes %0d)", $time,
                     oldest_verdict.looks_like_data, looks_like_data,
                     oldest_verdict.region_bytes);
            errors++;
          end
          if (region_bytes !== oldest_verdict.region_bytes) begin
            $display("%0t: region_bytes expected %0d got %0d", $time,
                     oldest_verdict.region_bytes, region_bytes);
            errors++;
          end
          verdicts_checked++;
          if (oldest_verdict.looks_like_data)
            data_verdicts++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [7:0] rand_print_byte();
    logic [7:0] b;
    b[6:0] = 7'($urandom_range(32'h20, 32'h7E));
    b[7]   = 1'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] rand_ctrl_byte();
    logic [7:0] b;
    b[6:0] = ($urandom_range(32) == 32) ? 7'h7F : 7'($urandom_range(31));
    b[7]   = 1'($urandom);
    return b;
  endfunction

  function automatic void queue_region(input logic [7:0] body[$]);
    cdrc_pkg::item_t it;
    foreach (body[i]) begin
      it.data_byte = body[i];
      it.last_byte = (i == body.size() - 1);
      byte_stream.push_back(it);
      bytes_queued++;
    end
    regions_queued++;
  endfunction

  function automatic void add_random_region();
    region_kind_e kind;
    logic [7:0]   body[$];
    logic [7:0]   b;
    logic [7:0]   fill;
    int           len;
    int           seg;
    kind = region_kind_e'($urandom_range(RG_CODE));
    len  = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(1, 20);
    seg  = $urandom_range(1, 8);
    fill = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      case (kind)
        RG_NOISE: begin
          b = 8'($urandom);
        end
        RG_TEXT: begin
          b = ($urandom_range(15) == 0) ? rand_ctrl_byte() : rand_print_byte();
        end
        RG_CSTRING: begin
          if (seg == 0) begin
            b   = 8'h00;
            seg = $urandom_range(1, 8);
          end else begin
            b = rand_print_byte();
            seg--;
          end
        end
        RG_REPEAT: begin
          if (seg == 0) begin
            fill = 8'($urandom);
            seg  = $urandom_range(1, 6);
          end
          b = fill;
          seg--;
        end
        RG_ADDR: begin
          // Even offsets carry the low byte; the high byte decides the range.
          if (i % 2 == 0) begin
            b = 8'($urandom);
          end else begin
            case ($urandom_range(2))
              0: b = 8'h00;
              1: b = 8'($urandom_range(1, 7));
              default: b = 8'($urandom_range(8, 255));
            endcase
          end
        end
        RG_RUNS: begin
          if (seg == 0) begin
            b   = rand_ctrl_byte();
            seg = ($urandom_range(2) == 0) ? $urandom_range(1, 4) : $urandom_range(4, 12);
          end else begin
            b = rand_print_byte();
            seg--;
          end
        end
        default: begin
          b = ($urandom_range(4) == 0) ? rand_print_byte() : rand_ctrl_byte();
        end
      endcase
      body.push_back(b);
    end
    queue_region(body);
  endfunction

  task automatic wait_drained();
    do
      @(negedge clk);
    while (byte_stream.size() != 0 || in_valid || verdicts_due.size() != 0);
  endtask

  initial begin
    logic [7:0] body[$];
    clear_region();
    send_idle_pct = 10;
    recv_idle_pct = 84;

    // Lone byte, short region, string followed by a NUL, final NUL,
    // printable window edges, and four equal bytes.
    body = '{8'hFF};
    queue_region(body);
    body = '{8'h80, 8'h7F, 8'hA0};
    queue_region(body);
    body = '{8'h61, 8'h62, 8'h63, 8'h00, 8'h64};
    queue_region(body);
    body = '{8'h20, 8'h7E, 8'h1F, 8'h00};
    queue_region(body);
    body = '{8'hAA, 8'hAA, 8'hAA, 8'hAA};
    queue_region(body);

    while (bytes_queued < 350)
      add_random_region();
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 10;
    while (bytes_queued < 700)
      add_random_region();
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (bytes_queued < 1000)
      add_random_region();
    wait_drained();
    repeat (8) @(negedge clk);

    $display("Sent %0d regions (%0d bytes) under three handshake stall profiles.",
             regions_queued, bytes_queued);
    $display("Checked %0d verdicts: %0d data, %0d code; %0d mismatches.",
             verdicts_checked, data_verdicts, verdicts_checked - data_verdicts, errors);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
